FILE: rtl/bcc_pkg.sv
// Shared types and constants of the button click classifier.
package bcc_pkg;

  localparam int unsigned HoldBitsDef = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TICK_MS      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP          = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PERIOD  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONG_MIN     = 3'd4;

  localparam logic [7:0]  TickMsRst     = 8'd20;
  localparam logic [7:0]  DebounceRst   = 8'd3;
  localparam logic [7:0]  GapRst        = 8'd40;
  localparam logic [7:0]  LongPeriodRst = 8'd25;
  localparam logic [15:0] LongMinRst    = 16'd20;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic        over;
    logic [31:0] hold;
  } bcc_word_t;

endpackage

FILE: rtl/button_click_classifier.sv
// Button click classifier: debounce, single, double and long press events.
//
// One tick word is taken per clock cycle when the block is not stalled. Each
// tick updates the hold, phase, debounce, gap and touch counters at the
// input; a tick that yields an event is registered in the event word
// register and then goes through the 32x8 press-time multiplier into the
// output register. in_stall_o rises only when both event registers
// are full and the output is stalled. Configuration writes are taken at any
// time and must be made while no event is in flight.
module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int unsigned HOLD_BITS = HoldBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          event_kind_o,
  output logic [31:0]         press_time_ms_o,
  output logic                is_double_o
);

  localparam logic [HOLD_BITS-1:0] HoldMax = {HOLD_BITS{1'b1}};

  logic [7:0]  tick_ms_q, debounce_q, gap_q, long_period_q;
  logic [15:0] long_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q     <= TickMsRst;
      debounce_q    <= DebounceRst;
      gap_q         <= GapRst;
      long_period_q <= LongPeriodRst;
      long_min_q    <= LongMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICK_MS:     tick_ms_q     <= cfg_data_i[7:0];
        CFG_DEBOUNCE:    debounce_q    <= cfg_data_i[7:0];
        CFG_GAP:         gap_q         <= cfg_data_i[7:0];
        CFG_LONG_PERIOD: long_period_q <= cfg_data_i[7:0];
        CFG_LONG_MIN:    long_min_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick state
  logic [HOLD_BITS-1:0] hold_q, hold_d;
  logic [7:0]           phase_q, phase_d;
  logic [7:0]           deb_q, deb_d;
  logic [1:0]           touch_q, touch_d;
  logic [7:0]           gapc_q, gapc_d;
  logic                 lock_q, lock_d;

  logic                 in_fire, s1_ready, out_ready;
  logic                 s1_valid_q, out_valid_q;
  bcc_word_t            s1_q, s1_d;
  logic                 have;
  logic [HOLD_BITS-1:0] hold_inc;
  logic [7:0]           phase_inc;
  logic [63:0]          hold_w;
  logic [1:0]           touch_nx;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  always_comb begin
    hold_inc  = hold_q;
    phase_inc = phase_q;
    if (hold_q != HoldMax) begin
      hold_inc  = hold_q + HOLD_BITS'(1);
      phase_inc = phase_q + 8'd1;
      if (long_period_q != 8'd0 && phase_inc >= long_period_q) begin
        phase_inc = 8'd0;
      end
    end
    hold_w = 64'(hold_inc);

    have     = 1'b0;
    s1_d     = '{kind: KIND_SINGLE, over: |hold_w[63:32], hold: hold_w[31:0]};
    deb_d    = deb_q;
    touch_d  = touch_q;
    gapc_d   = gapc_q;
    lock_d   = lock_q;
    touch_nx = touch_q + 2'd1;

    if (level_i) begin
      lock_d = 1'b0;
      deb_d  = 8'd0;
      if (touch_q != 2'd0) begin
        if (gapc_q != 8'hFF) begin
          gapc_d = gapc_q + 8'd1;
        end
        if (gapc_d > gap_q) begin
          gapc_d  = 8'd0;
          touch_d = 2'd0;
          have    = 1'b1;
        end
      end
    end else if (!lock_q) begin
      if (deb_q != 8'hFF) begin
        deb_d = deb_q + 8'd1;
      end
      if (deb_d > debounce_q) begin
        deb_d   = 8'd0;
        lock_d  = 1'b1;
        gapc_d  = 8'd0;
        touch_d = touch_nx;
        if (touch_nx > 2'd1) begin
          touch_d     = 2'd0;
          have        = 1'b1;
          s1_d.kind   = KIND_DOUBLE;
        end
      end
    end

    if (!level_i && phase_inc == 8'd0 && hold_inc >= HOLD_BITS'(long_min_q)) begin
      touch_d = 2'd0;
      if (!have) begin
        have      = 1'b1;
        s1_d.kind = KIND_LONG;
      end
    end

    hold_d  = level_i ? '0 : hold_inc;
    phase_d = level_i ? 8'd0 : phase_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      phase_q <= 8'd0;
      deb_q   <= 8'd0;
      touch_q <= 2'd0;
      gapc_q  <= 8'd0;
      lock_q  <= 1'b0;
    end else if (in_fire) begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
      deb_q   <= deb_d;
      touch_q <= touch_d;
      gapc_q  <= gapc_d;
      lock_q  <= lock_d;
    end
  end

  // Event word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_fire && have;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && have) begin
      s1_q <= s1_d;
    end
  end

  // Press time and output register
  logic [39:0] prod;
  logic [31:0] ptime;
  event_kind_e kind_q;
  logic [31:0] ptime_q;

  assign prod  = 40'(s1_q.hold) * 40'(tick_ms_q);
  assign ptime = (s1_q.over || |prod[39:32]) ? 32'hFFFF_FFFF : prod[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      kind_q  <= s1_q.kind;
      ptime_q <= ptime;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign press_time_ms_o = ptime_q;
  assign is_double_o     = (kind_q == KIND_DOUBLE);

endmodule

FILE: rtl/bcc_checker.sv
// Port checker for the button click classifier and its bind.
module bcc_checker
  import bcc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  event_kind_o,
  input logic [31:0] press_time_ms_o,
  input logic        is_double_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(press_time_ms_o))
    else $error("stalled event word changed");

  a_double_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_double_o == (event_kind_o == KIND_DOUBLE)))
    else $error("is_double disagrees with event kind");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  a_stall_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(is_double_o))
    else $error("stalled double flag changed");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);

FILE: sim/button_click_classifier_test.sv
// Self-checking testbench for the button click classifier: predicted events vs. DUT.
`timescale 1ns / 100ps

module button_click_classifier_test;
  import bcc_pkg::*;

  localparam int ClkHalf      = 4;
  localparam int ResetCycles  = 6;
  localparam int SettleCycles = 6;
  localparam int StuckLimit   = 2000;

  typedef struct {
    event_kind_e kind;
    logic [31:0] ms;
    logic        dbl;
  } click_event_t;

  class click_scoreboard;
    logic [7:0]   tick_ms, debounce_ticks, gap_ticks, long_period;
    logic [15:0]  long_min;
    logic [31:0]  hold_count;
    logic [7:0]   long_phase, debounce_count, gap_count;
    logic [1:0]   touch_count;
    logic         press_lock;
    click_event_t pending_events[$];
    int           errors;

    function new();
      tick_ms        = TickMsRst;
      debounce_ticks = DebounceRst;
      gap_ticks      = GapRst;
      long_period    = LongPeriodRst;
      long_min       = LongMinRst;
      hold_count     = '0;
      long_phase     = '0;
      debounce_count = '0;
      gap_count      = '0;
      touch_count    = '0;
      press_lock     = 1'b0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TICK_MS:     tick_ms        = data[7:0];
        CFG_DEBOUNCE:    debounce_ticks = data[7:0];
        CFG_GAP:         gap_ticks      = data[7:0];
        CFG_LONG_PERIOD: long_period    = data[7:0];
        CFG_LONG_MIN:    long_min       = data;
        default: ;
      endcase
    endfunction

    function void predict_tick(logic released);
      logic [39:0]  prod;
      logic [31:0]  ms;
      logic         have;
      event_kind_e  kind;
      click_event_t ev;
      have = 1'b0;
      kind = KIND_SINGLE;
      if (hold_count != '1) begin
        hold_count = hold_count + 32'd1;
        long_phase = long_phase + 8'd1;
        if (long_period != 8'd0 && long_phase >= long_period) long_phase = 8'd0;
      end
      prod = hold_count * tick_ms;
      ms = (prod > 40'h00_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];

      if (released) begin
        press_lock     = 1'b0;
        debounce_count = 8'd0;
        if (touch_count != 2'd0) begin
          if (gap_count != 8'hFF) gap_count = gap_count + 8'd1;
          if (gap_count > gap_ticks) begin
            gap_count   = 8'd0;
            touch_count = 2'd0;
            have        = 1'b1;
            kind        = KIND_SINGLE;
          end
        end
      end else if (!press_lock) begin
        if (debounce_count != 8'hFF) debounce_count = debounce_count + 8'd1;
        if (debounce_count > debounce_ticks) begin
          debounce_count = 8'd0;
          press_lock     = 1'b1;
          gap_count      = 8'd0;
          touch_count    = touch_count + 2'd1;
          if (touch_count > 2'd1) begin
            touch_count = 2'd0;
            have        = 1'b1;
            kind        = KIND_DOUBLE;
          end
        end
      end

      // double press wins over a long press on the same tick
      if (!released && long_phase == 8'd0 && hold_count >= long_min) begin
        touch_count = 2'd0;
        if (!have) begin
          have = 1'b1;
          kind = KIND_LONG;
        end
      end

      if (released) begin
        hold_count = '0;
        long_phase = 8'd0;
      end

      if (have) begin
        ev.kind = kind;
        ev.ms   = ms;
        ev.dbl  = (kind == KIND_DOUBLE);
        pending_events.push_back(ev);
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [31:0] ms, logic dbl);
      click_event_t ev;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event word, kind %0d time %0d double %0d",
                 $time, kind, ms, dbl);
        return;
      end
      ev = pending_events.pop_front();
      if (kind != ev.kind) begin
        errors++;
        $display("%0t: event kind expected %0d actual %0d", $time, ev.kind, kind);
      end
      if (ms != ev.ms) begin
        errors++;
        $display("%0t: press time expected %0d actual %0d", $time, ev.ms, ms);
      end
      if (dbl != ev.dbl) begin
        errors++;
        $display("%0t: double flag expected %0d actual %0d", $time, ev.dbl, dbl);
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_TICK_MS;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                level_i     = 1'b1;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [1:0]          event_kind_o;
  logic [31:0]         press_time_ms_o;
  logic                is_double_o;

  click_scoreboard sb = new();
  bit              calm = 1'b0;
  int              tick_count = 0;
  int              stuck_cycles = 0;
  int              cur_deb, cur_gap, cur_per, cur_min;

  button_click_classifier DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .level_i,
    .out_valid_o,
    .out_stall_i,
    .event_kind_o,
    .press_time_ms_o,
    .is_double_o
  );

  always #ClkHalf clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_event(event_kind_o, press_time_ms_o, is_double_o);
    end
    out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StuckLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_tick(input logic lvl);
    if (!calm && $urandom_range(99) < 10) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_tick(lvl);
    tick_count++;
  endtask

  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits of the 8-bit registers are random and must be dropped
  task automatic program_regs(input int tick, input int deb, input int gap, input int per,
                              input int lmin);
    settle();
    write_reg(CFG_TICK_MS, {8'($urandom_range(255)), 8'(tick)});
    write_reg(CFG_DEBOUNCE, {8'($urandom_range(255)), 8'(deb)});
    write_reg(CFG_GAP, {8'($urandom_range(255)), 8'(gap)});
    write_reg(CFG_LONG_PERIOD, {8'($urandom_range(255)), 8'(per)});
    write_reg(CFG_LONG_MIN, 16'(lmin));
    write_reg(CfgIdxW'($urandom_range(7, CFG_LONG_MIN + 1)), 16'($urandom_range(65535)));
    cur_deb = deb;
    cur_gap = gap;
    cur_per = per;
    cur_min = lmin;
  endtask

  task automatic run_press(input int press_len, input int rel_len);
    repeat (press_len) send_tick(1'b0);
    repeat (rel_len) send_tick(1'b1);
  endtask

  task automatic run_noise(input int n);
    repeat (n) send_tick(1'($urandom_range(1)));
  endtask

  task automatic run_phase(input int budget);
    int start, eff_per, press_len, rel_len, pick;
    start   = tick_count;
    eff_per = (cur_per == 0) ? 256 : cur_per;
    while (tick_count - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        run_noise($urandom_range(1, 6));
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          press_len = cur_deb + 1 + $urandom_range(0, 3);
        end else if (pick < 75) begin
          press_len = $urandom_range(1, cur_deb + 2);
        end else begin
          press_len = ((cur_min > cur_deb) ? cur_min : cur_deb + 1) +
                      $urandom_range(0, 2 * eff_per);
        end
        if (press_len > 200) press_len = 200;
        if ($urandom_range(1)) begin
          rel_len = $urandom_range(1, (cur_gap < 15) ? cur_gap : 15);
        end else begin
          rel_len = cur_gap + 1 + $urandom_range(0, 2);
        end
        run_press(press_len, rel_len);
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // double press landing on a long-press tick, then a plain long repeat
    program_regs(255, 1, 10, 2, 100);
    run_press(2, 1);
    settle();
    write_reg(CFG_LONG_MIN, 16'd0);
    cur_min = 0;
    run_press(4, 1);

    // single and double press at tick 1, zero debounce and a gap of 1
    program_regs(1, 0, 1, 200, 65535);
    run_press(1, 2);
    run_press(1, 1);
    run_press(1, 1);

    // period lowered below the running phase while held
    settle();
    write_reg(CFG_LONG_MIN, 16'd0);
    cur_min = 0;
    run_press(6, 0);
    settle();
    write_reg(CFG_LONG_PERIOD, 16'd3);
    cur_per = 3;
    run_press(1, 1);

    calm = 1'b1;
    program_regs($urandom_range(1, 255), $urandom_range(0, 4), $urandom_range(1, 12),
                 $urandom_range(1, 12), $urandom_range(0, 30));
    run_phase(80);
    calm = 1'b0;

    repeat (2) begin
      program_regs($urandom_range(1, 255), $urandom_range(0, 4), $urandom_range(1, 12),
                   $urandom_range(1, 12), $urandom_range(0, 30));
      run_phase(80);
    end

    program_regs(TickMsRst, DebounceRst, GapRst, LongPeriodRst, LongMinRst);
    run_phase(80);

    program_regs(255, 0, 1, 1, 0);
    run_phase(60);

    // zero period wraps at 256; zero tick gives zero press time
    program_regs(0, 254, 255, 0, 0);
    run_press(257, 2);

    // debounce of 255 never accepts a press
    program_regs($urandom_range(1, 255), 255, 254, 255, 65535);
    run_noise(24);
    run_press(12, 3);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
